// File: rtl/mbglyph_pkg.sv
package mbglyph_pkg;

    // Language modes held in the configuration register
    typedef enum logic [1:0] {
        LANG_ASCII = 2'd0,
        LANG_SJIS  = 2'd1,
        LANG_EUC   = 2'd2,
        LANG_GB    = 2'd3
    } t_lang_mode;

    // Shift-JIS lead byte ranges
    localparam logic [7:0] SJ_LEAD_A_LO = 8'h81;
    localparam logic [7:0] SJ_LEAD_A_HI = 8'h9f;
    localparam logic [7:0] SJ_LEAD_B_LO = 8'he0;
    localparam logic [7:0] SJ_LEAD_B_HI = 8'hfc;

    // Shift-JIS trail byte ranges
    localparam logic [7:0] SJ_TRAIL_A_LO = 8'h40;
    localparam logic [7:0] SJ_TRAIL_A_HI = 8'h7e;
    localparam logic [7:0] SJ_TRAIL_B_LO = 8'h80;
    localparam logic [7:0] SJ_TRAIL_B_HI = 8'h9e;
    localparam logic [7:0] SJ_TRAIL_C_LO = 8'h9f;

    // Shift-JIS row and cell bases
    localparam logic [7:0] SJ_ROW_B_BASE  = 8'd62;
    localparam logic [7:0] SJ_CELL_B_BASE = 8'd63;

    // EUC-style and GB-style lead and trail byte range
    localparam logic [7:0] EUC_LO      = 8'ha1;
    localparam logic [7:0] EUC_HI      = 8'hfe;
    localparam logic [7:0] EUC_LEAD_LO = 8'h81;

    // Font table geometry
    localparam logic [13:0] ROW_CELLS        = 14'd94;
    localparam logic [18:0] BIG_BASE         = 19'd4096;
    localparam logic [18:0] GLYPH_HALF_BYTES = 19'd16;
    localparam logic [15:0] CELL_STEP_X      = 16'd8;

    // One glyph descriptor
    typedef struct packed {
        logic               font_select;
        logic [18:0]        font_offset;
        logic               glyph_kind;
        logic signed [15:0] draw_x;
        logic               bad_code;
        logic               last_of_run;
    } t_glyph;

endpackage

// File: rtl/mbglyph_text_if.sv
interface mbglyph_text_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_byte;
    logic        string_start;
    logic [11:0] start_x;

    modport source(output valid, output char_byte, output string_start, output start_x,
                   input ready);
    modport sink(input valid, input char_byte, input string_start, input start_x,
                 output ready);
endinterface

// File: rtl/mbglyph_glyph_if.sv
interface mbglyph_glyph_if;
    logic               valid;
    logic               ready;
    logic               font_select;
    logic [18:0]        font_offset;
    logic               glyph_kind;
    logic signed [15:0] draw_x;
    logic               bad_code;
    logic               last_of_run;

    modport source(output valid, output font_select, output font_offset, output glyph_kind,
                   output draw_x, output bad_code, output last_of_run, input ready);
    modport sink(input valid, input font_select, input font_offset, input glyph_kind,
                 input draw_x, input bad_code, input last_of_run, output ready);
endinterface

// File: rtl/mbglyph_cfg_if.sv
interface mbglyph_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] lang_mode;

    modport source(output valid, output lang_mode, input ready);
    modport sink(input valid, input lang_mode, output ready);
endinterface

// File: rtl/multibyte_text_to_glyph_index.sv
// Text byte to glyph descriptor converter. Each text word is taken into an
// input register, decoded against the pending lead byte and the running
// cursor once the result register can take it, and its zero, one or two
// descriptors land in a two-entry result register that drains one descriptor
// per cycle while the receiver is ready. A Shift-JIS or EUC pair that gives
// two descriptors holds the single result channel for both. The first
// descriptor passes the input register and then the result register.
// The mode register may be written only while the block is empty.
module multibyte_text_to_glyph_index (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    mbglyph_cfg_if.sink             i_cfg,
    mbglyph_text_if.sink            i_text,
    mbglyph_glyph_if.source         o_glyph
);

    // Configuration and decode state
    mbglyph_pkg::t_lang_mode r_mode;
    logic [7:0]              r_pending;
    logic [15:0]             r_cursor;

    // Input register
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_start;
    logic [11:0]             r_in_start_x;

    // Result register, entry 0 is at the output
    mbglyph_pkg::t_glyph     r_res [2];
    logic [1:0]              r_cnt;

    // Decode outputs
    mbglyph_pkg::t_glyph     n_res0;
    mbglyph_pkg::t_glyph     n_res1;
    logic [1:0]              n_cnt;
    logic [7:0]              n_pending;
    logic [15:0]             n_cursor;

    logic                    pop;
    logic                    can_load;
    logic                    dec_fire;

    assign i_cfg.ready = 1'b1;

    assign pop      = o_glyph.valid && o_glyph.ready;
    assign can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign dec_fire = r_in_valid && can_load;

    assign i_text.ready = !r_in_valid || dec_fire;

    // Output word
    assign o_glyph.valid       = (r_cnt != 2'd0);
    assign o_glyph.font_select = r_res[0].font_select;
    assign o_glyph.font_offset = r_res[0].font_offset;
    assign o_glyph.glyph_kind  = r_res[0].glyph_kind;
    assign o_glyph.draw_x      = r_res[0].draw_x;
    assign o_glyph.bad_code    = r_res[0].bad_code;
    assign o_glyph.last_of_run = r_res[0].last_of_run;

    // Decode of the registered byte
    always_comb begin
        logic [15:0]        x;
        logic [15:0]        xl;
        logic [7:0]         b;
        logic [7:0]         lb;
        logic               is_lead;
        logic               lb_in_a;
        logic signed [9:0]  lbs;
        logic signed [9:0]  sbs;
        logic signed [9:0]  k;
        logic signed [9:0]  t;
        logic [13:0]        cell_idx;
        logic [18:0]        cell_off;
        logic [18:0]        base;
        logic [18:0]        single_off;
        logic               neg;

        b   = r_in_byte;
        lb  = r_pending;
        x   = r_in_start ? {4'b0, r_in_start_x} : r_cursor;
        xl  = x - mbglyph_pkg::CELL_STEP_X;
        lbs = signed'({2'b00, lb});
        sbs = signed'({2'b00, b});
        single_off = {7'b0, b, 4'b0};

        // Lead byte detection per mode
        unique case (r_mode)
            mbglyph_pkg::LANG_SJIS:
                is_lead = (b >= mbglyph_pkg::SJ_LEAD_A_LO && b <= mbglyph_pkg::SJ_LEAD_A_HI) ||
                          (b >= mbglyph_pkg::SJ_LEAD_B_LO && b <= mbglyph_pkg::SJ_LEAD_B_HI);
            mbglyph_pkg::LANG_EUC:
                is_lead = (b >= mbglyph_pkg::EUC_LEAD_LO && b <= mbglyph_pkg::EUC_HI);
            mbglyph_pkg::LANG_GB:
                is_lead = (b >= mbglyph_pkg::EUC_LO && b <= mbglyph_pkg::EUC_HI);
            default:
                is_lead = 1'b0;
        endcase

        // Row and cell of a pair
        lb_in_a = (lb >= mbglyph_pkg::SJ_LEAD_A_LO) && (lb <= mbglyph_pkg::SJ_LEAD_A_HI);
        if (r_mode == mbglyph_pkg::LANG_SJIS) begin
            if (lb_in_a) begin
                k = (lbs - signed'({2'b00, mbglyph_pkg::SJ_LEAD_A_LO})) * 10'sd2;
            end else begin
                k = (lbs - signed'({2'b00, mbglyph_pkg::SJ_LEAD_B_LO})) * 10'sd2
                    + signed'({2'b00, mbglyph_pkg::SJ_ROW_B_BASE});
            end
            if (b >= mbglyph_pkg::SJ_TRAIL_A_LO && b <= mbglyph_pkg::SJ_TRAIL_A_HI) begin
                t = sbs - signed'({2'b00, mbglyph_pkg::SJ_TRAIL_A_LO});
            end else if (b >= mbglyph_pkg::SJ_TRAIL_B_LO && b <= mbglyph_pkg::SJ_TRAIL_B_HI) begin
                t = sbs - signed'({2'b00, mbglyph_pkg::SJ_TRAIL_B_LO})
                    + signed'({2'b00, mbglyph_pkg::SJ_CELL_B_BASE});
            end else begin
                t = sbs - signed'({2'b00, mbglyph_pkg::SJ_TRAIL_C_LO});
                k = k + 10'sd1;
            end
        end else begin
            k = lbs - signed'({2'b00, mbglyph_pkg::EUC_LO});
            t = sbs - signed'({2'b00, mbglyph_pkg::EUC_LO});
        end
        neg      = k[9] || t[9];
        cell_idx = {7'b0, k[6:0]} * mbglyph_pkg::ROW_CELLS + {7'b0, t[6:0]};
        cell_off = {cell_idx, 5'b0};
        base     = cell_off + mbglyph_pkg::BIG_BASE;

        // Defaults: single descriptor, nothing drawn twice
        n_res0             = '0;
        n_res0.draw_x      = signed'(x);
        n_res0.font_offset = single_off;
        n_res0.last_of_run = 1'b1;
        n_res1             = '0;
        n_res1.font_select = 1'b1;
        n_res1.font_offset = base + mbglyph_pkg::GLYPH_HALF_BYTES;
        n_res1.draw_x      = signed'(x);
        n_res1.last_of_run = 1'b1;
        n_pending          = r_pending;
        n_cnt              = 2'd1;
        n_cursor           = x + mbglyph_pkg::CELL_STEP_X;

        priority if (r_mode == mbglyph_pkg::LANG_ASCII) begin
            n_cnt = 2'd1;
        end else if (r_pending == 8'd0) begin
            if (is_lead) begin
                n_pending = b;
                n_cnt     = 2'd0;
            end else begin
                n_res0.font_select = (r_mode != mbglyph_pkg::LANG_GB);
            end
        end else begin
            n_pending          = 8'd0;
            n_res0.font_select = 1'b1;
            n_res0.glyph_kind  = (r_mode == mbglyph_pkg::LANG_GB);
            n_res0.draw_x      = signed'(xl);
            if (neg) begin
                n_res0.font_offset = '0;
                n_res0.bad_code    = 1'b1;
            end else if (r_mode == mbglyph_pkg::LANG_GB) begin
                n_res0.font_offset = cell_off;
            end else begin
                n_res0.font_offset = base;
                n_res0.last_of_run = 1'b0;
                n_cnt              = 2'd2;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= mbglyph_pkg::LANG_ASCII;
            r_pending  <= 8'd0;
            r_cursor   <= 16'd0;
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_mode <= mbglyph_pkg::t_lang_mode'(i_cfg.lang_mode);
            end
            if (i_text.valid && i_text.ready) begin
                r_in_valid <= 1'b1;
            end else if (dec_fire) begin
                r_in_valid <= 1'b0;
            end
            if (dec_fire) begin
                r_pending <= n_pending;
                r_cursor  <= n_cursor;
                r_cnt     <= n_cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte    <= i_text.char_byte;
            r_in_start   <= i_text.string_start;
            r_in_start_x <= i_text.start_x;
        end
        if (dec_fire) begin
            r_res[0] <= n_res0;
            r_res[1] <= n_res1;
        end else if (pop) begin
            r_res[0] <= r_res[1];
        end
    end

    // Checks
    a_load_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_fire |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)))
        else $error("decode overwrote an undelivered descriptor");

    a_pair_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_res[0].last_of_run)
        else $error("first half of a pair marked last");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_res[0].last_of_run)
        else $error("final descriptor of a byte not marked last");

    a_ascii_keeps_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec_fire && r_mode == mbglyph_pkg::LANG_ASCII) |=> $stable(r_pending))
        else $error("pending lead changed in ascii mode");

    a_bad_has_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_glyph.valid && o_glyph.bad_code) |-> (o_glyph.font_offset == '0 &&
                                                 o_glyph.font_select))
        else $error("flagged code carries a glyph offset");

endmodule

// File: bench/tb.sv
module tb;

    localparam int          HALF_PERIOD   = 5;
    localparam int          RESET_CYCLES  = 6;
    // lead bytes give no descriptor, so let the pipe empty before a mode write
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          RUN_LIMIT     = 5_000_000;
    localparam int          PHASE_WORDS   = 60;
    localparam int          NUM_PHASES    = 8;
    localparam logic [7:0]  SJ_TRAIL_TOP  = 8'hfc;

    // Expected glyph descriptors, predicted from each accepted text word
    class glyph_ledger;
        mbglyph_pkg::t_lang_mode mode;
        logic [7:0]              held_lead;
        logic [15:0]             pen_x;
        mbglyph_pkg::t_glyph     want_q[$];
        int                      faults;

        function new();
            mode      = mbglyph_pkg::LANG_ASCII;
            held_lead = 8'd0;
            pen_x     = 16'd0;
            faults    = 0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void queue_glyph(logic sel, logic [18:0] off, logic kind, logic [15:0] x,
                                  logic bad, logic last);
            mbglyph_pkg::t_glyph g;
            g.font_select = sel;
            g.font_offset = off;
            g.glyph_kind  = kind;
            g.draw_x      = x;
            g.bad_code    = bad;
            g.last_of_run = last;
            want_q.push_back(g);
        endfunction

        function void take_byte(logic [7:0] b, logic st, logic [11:0] sx);
            logic [15:0] x;
            logic [15:0] xl;
            logic        is_lead;
            logic [18:0] glyph_ofs;
            int          lv;
            int          tv;
            int          k;
            int          t;
            if (st)
                pen_x = {4'd0, sx};
            x  = pen_x;
            xl = pen_x - mbglyph_pkg::CELL_STEP_X;
            if (mode == mbglyph_pkg::LANG_ASCII) begin
                // plain text; a held lead stays untouched
                queue_glyph(1'b0, {11'd0, b} * mbglyph_pkg::GLYPH_HALF_BYTES, 1'b0, x,
                            1'b0, 1'b1);
            end else if (held_lead == 8'd0) begin
                case (mode)
                    mbglyph_pkg::LANG_SJIS:
                        is_lead = (b >= mbglyph_pkg::SJ_LEAD_A_LO &&
                                   b <= mbglyph_pkg::SJ_LEAD_A_HI) ||
                                  (b >= mbglyph_pkg::SJ_LEAD_B_LO &&
                                   b <= mbglyph_pkg::SJ_LEAD_B_HI);
                    mbglyph_pkg::LANG_EUC:
                        is_lead = (b >= mbglyph_pkg::EUC_LEAD_LO && b <= mbglyph_pkg::EUC_HI);
                    default:
                        is_lead = (b >= mbglyph_pkg::EUC_LO && b <= mbglyph_pkg::EUC_HI);
                endcase
                if (is_lead)
                    held_lead = b;
                else
                    queue_glyph(mode != mbglyph_pkg::LANG_GB,
                                {11'd0, b} * mbglyph_pkg::GLYPH_HALF_BYTES, 1'b0, x,
                                1'b0, 1'b1);
            end else begin
                lv        = int'(held_lead);
                tv        = int'(b);
                held_lead = 8'd0;
                if (mode == mbglyph_pkg::LANG_SJIS) begin
                    // row from lead, cell from trail; third trail range bumps the row
                    if (lv >= mbglyph_pkg::SJ_LEAD_A_LO && lv <= mbglyph_pkg::SJ_LEAD_A_HI)
                        k = (lv - mbglyph_pkg::SJ_LEAD_A_LO) * 2;
                    else
                        k = (lv - mbglyph_pkg::SJ_LEAD_B_LO) * 2 + mbglyph_pkg::SJ_ROW_B_BASE;
                    if (tv >= mbglyph_pkg::SJ_TRAIL_A_LO &&
                        tv <= mbglyph_pkg::SJ_TRAIL_A_HI) begin
                        t = tv - mbglyph_pkg::SJ_TRAIL_A_LO;
                    end else if (tv >= mbglyph_pkg::SJ_TRAIL_B_LO &&
                                 tv <= mbglyph_pkg::SJ_TRAIL_B_HI) begin
                        t = tv - mbglyph_pkg::SJ_TRAIL_B_LO + mbglyph_pkg::SJ_CELL_B_BASE;
                    end else begin
                        t = tv - mbglyph_pkg::SJ_TRAIL_C_LO;
                        k = k + 1;
                    end
                end else begin
                    k = lv - mbglyph_pkg::EUC_LO;
                    t = tv - mbglyph_pkg::EUC_LO;
                end
                if (k < 0 || t < 0) begin
                    queue_glyph(1'b1, 19'd0, mode == mbglyph_pkg::LANG_GB, xl, 1'b1, 1'b1);
                end else begin
                    glyph_ofs = 19'((k * mbglyph_pkg::ROW_CELLS + t) *
                                    mbglyph_pkg::GLYPH_HALF_BYTES * 2);
                    if (mode == mbglyph_pkg::LANG_GB) begin
                        queue_glyph(1'b1, glyph_ofs, 1'b1, xl, 1'b0, 1'b1);
                    end else begin
                        queue_glyph(1'b1, mbglyph_pkg::BIG_BASE + glyph_ofs, 1'b0, xl,
                                    1'b0, 1'b0);
                        queue_glyph(1'b1, mbglyph_pkg::BIG_BASE + glyph_ofs +
                                    mbglyph_pkg::GLYPH_HALF_BYTES, 1'b0, x, 1'b0, 1'b1);
                    end
                end
            end
            pen_x = pen_x + mbglyph_pkg::CELL_STEP_X;
        endfunction

        function void match_glyph(mbglyph_pkg::t_glyph got);
            mbglyph_pkg::t_glyph want;
            if (want_q.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected glyph: sel=%0d off=%h kind=%0d x=%0d bad=%0d last=%0d",
                             got.font_select, got.font_offset, got.glyph_kind, got.draw_x,
                             got.bad_code, got.last_of_run);
                return;
            end
            want = want_q.pop_front();
            if (got.font_select !== want.font_select || got.font_offset !== want.font_offset ||
                got.glyph_kind !== want.glyph_kind || got.draw_x !== want.draw_x ||
                got.bad_code !== want.bad_code || got.last_of_run !== want.last_of_run) begin
                faults++;
                if (faults <= 10) begin
                    $display("glyph mismatch at %0t", $time);
                    $display("  expected sel=%0d off=%h kind=%0d x=%0d bad=%0d last=%0d",
                             want.font_select, want.font_offset, want.glyph_kind, want.draw_x,
                             want.bad_code, want.last_of_run);
                    $display("  actual   sel=%0d off=%h kind=%0d x=%0d bad=%0d last=%0d",
                             got.font_select, got.font_offset, got.glyph_kind, got.draw_x,
                             got.bad_code, got.last_of_run);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mbglyph_cfg_if   cfg_bus();
    mbglyph_text_if  text_bus();
    mbglyph_glyph_if glyph_bus();

    glyph_ledger ledger = new();

    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;
    int words_sent = 0;

    multibyte_text_to_glyph_index u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_text  (text_bus),
        .o_glyph (glyph_bus)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap(bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one text word and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic st, input logic [11:0] sx);
        int gap;
        gap = idle_gap(tx_idle);
        if (gap > 0) begin
            text_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_bus.valid        <= 1'b1;
        text_bus.char_byte    <= b;
        text_bus.string_start <= st;
        text_bus.start_x      <= sx;
        @(posedge i_clk);
        while (!text_bus.ready) @(posedge i_clk);
        ledger.take_byte(b, st, sx);
        words_sent++;
    endtask

    // Mode write, only once the block has gone quiet
    task automatic write_mode(input mbglyph_pkg::t_lang_mode m);
        text_bus.valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.lang_mode <= m;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        ledger.mode = m;
        cfg_bus.valid <= 1'b0;
    endtask

    // One character: mostly a well-formed pair in multibyte modes, else a raw byte
    task automatic send_random_char(input mbglyph_pkg::t_lang_mode m);
        logic [7:0]  lead;
        logic [7:0]  trail;
        logic        st;
        logic [11:0] sx;
        st = ($urandom_range(0, 11) == 0);
        sx = 12'($urandom_range(0, 4095));
        if (m == mbglyph_pkg::LANG_ASCII || $urandom_range(0, 4) == 0) begin
            send_byte(8'($urandom_range(0, 255)), st, sx);
        end else begin
            if (m == mbglyph_pkg::LANG_SJIS) begin
                if ($urandom_range(0, 1))
                    lead = 8'($urandom_range(mbglyph_pkg::SJ_LEAD_A_LO,
                                             mbglyph_pkg::SJ_LEAD_A_HI));
                else
                    lead = 8'($urandom_range(mbglyph_pkg::SJ_LEAD_B_LO,
                                             mbglyph_pkg::SJ_LEAD_B_HI));
                if ($urandom_range(0, 2) == 0)
                    trail = 8'($urandom_range(mbglyph_pkg::SJ_TRAIL_A_LO,
                                              mbglyph_pkg::SJ_TRAIL_A_HI));
                else
                    trail = 8'($urandom_range(mbglyph_pkg::SJ_TRAIL_B_LO, SJ_TRAIL_TOP));
            end else begin
                lead  = 8'($urandom_range(mbglyph_pkg::EUC_LO, mbglyph_pkg::EUC_HI));
                trail = 8'($urandom_range(mbglyph_pkg::EUC_LO, mbglyph_pkg::EUC_HI));
            end
            send_byte(lead, st, sx);
            send_byte(trail, $urandom_range(0, 11) == 0, 12'($urandom_range(0, 4095)));
        end
    endtask

    // Result side ready, with random stalls and one long hold-off on request
    initial begin : glyph_ready_drive
        int gap;
        int held;
        glyph_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                glyph_bus.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
            end
            gap = idle_gap(rx_idle);
            if (gap > 0) begin
                glyph_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            glyph_bus.ready <= 1'b1;
        end
    end

    // Check every accepted descriptor
    always @(posedge i_clk) begin
        mbglyph_pkg::t_glyph got;
        if (i_rst_n && glyph_bus.valid && glyph_bus.ready) begin
            got.font_select = glyph_bus.font_select;
            got.font_offset = glyph_bus.font_offset;
            got.glyph_kind  = glyph_bus.glyph_kind;
            got.draw_x      = glyph_bus.draw_x;
            got.bad_code    = glyph_bus.bad_code;
            got.last_of_run = glyph_bus.last_of_run;
            ledger.match_glyph(got);
        end
    end

    // Stimulus
    initial begin : text_stream
        mbglyph_pkg::t_lang_mode mode_order[NUM_PHASES];
        int                      phase_start;
        int                      drain;
        bit                      hold_done;
        mode_order = '{mbglyph_pkg::LANG_SJIS, mbglyph_pkg::LANG_GB, mbglyph_pkg::LANG_EUC,
                       mbglyph_pkg::LANG_ASCII, mbglyph_pkg::LANG_EUC, mbglyph_pkg::LANG_SJIS,
                       mbglyph_pkg::LANG_GB, mbglyph_pkg::LANG_ASCII};
        hold_done             = 1'b0;
        text_bus.valid        <= 1'b0;
        text_bus.char_byte    <= 8'd0;
        text_bus.string_start <= 1'b0;
        text_bus.start_x      <= 12'd0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.lang_mode     <= mbglyph_pkg::LANG_ASCII;
        i_rst_n               <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain text at the byte and position extremes
        write_mode(mbglyph_pkg::LANG_ASCII);
        send_byte(8'h00, 1'b1, 12'd0);
        send_byte(8'hff, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::SJ_LEAD_A_LO, 1'b1, 12'hfff);

        // Shift-JIS: first cell with left half wrapping below zero,
        // third trail range, second lead range, bad trail, plain bytes
        write_mode(mbglyph_pkg::LANG_SJIS);
        send_byte(mbglyph_pkg::SJ_LEAD_A_LO, 1'b1, 12'd0);
        send_byte(mbglyph_pkg::SJ_TRAIL_A_LO, 1'b1, 12'd0);
        send_byte(mbglyph_pkg::SJ_LEAD_A_HI, 1'b0, 12'd0);
        send_byte(SJ_TRAIL_TOP, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::SJ_LEAD_B_LO, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::SJ_TRAIL_B_HI, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::SJ_LEAD_B_HI, 1'b0, 12'd0);
        send_byte(8'h3f, 1'b0, 12'd0);
        send_byte(8'h41, 1'b0, 12'd0);
        send_byte(8'ha0, 1'b1, 12'hfff);

        // EUC: lead below the row range, cell beyond the last one, plain byte,
        // then a lead left hanging across the mode write
        write_mode(mbglyph_pkg::LANG_EUC);
        send_byte(mbglyph_pkg::EUC_LEAD_LO, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::EUC_LO, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::EUC_HI, 1'b0, 12'd0);
        send_byte(8'hff, 1'b0, 12'd0);
        send_byte(8'h20, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::EUC_LO, 1'b0, 12'd0);

        // GB: held lead finishes here, bad trail, plain byte, lead left hanging
        write_mode(mbglyph_pkg::LANG_GB);
        send_byte(mbglyph_pkg::EUC_LO, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::EUC_HI, 1'b0, 12'd0);
        send_byte(8'h00, 1'b0, 12'd0);
        send_byte(8'h80, 1'b0, 12'd0);
        send_byte(mbglyph_pkg::SJ_LEAD_B_LO, 1'b0, 12'd0);

        // plain text must neither use nor drop the held lead
        write_mode(mbglyph_pkg::LANG_ASCII);
        send_byte(8'h55, 1'b0, 12'd0);
        write_mode(mbglyph_pkg::LANG_SJIS);
        send_byte(mbglyph_pkg::SJ_TRAIL_A_LO, 1'b0, 12'd0);

        // random phases, each under its own mode and idle pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_mode(mode_order[p]);
            tx_idle     = ($urandom_range(0, 3) != 0);
            rx_idle     = ($urandom_range(0, 3) != 0);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                // long receiver hold-off while words keep coming
                if (p == 1 && !hold_done && words_sent - phase_start >= 6) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                send_random_char(mode_order[p]);
            end
        end
        text_bus.valid <= 1'b0;

        drain = 0;
        while (ledger.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.pending() != 0) begin
            $display("%0d expected glyphs never arrived", ledger.pending());
            ledger.faults += ledger.pending();
        end
        if (ledger.faults == 0) begin
            $display("** multibyte_text_to_glyph_index: PASSED **");
        end else begin
            $display("** multibyte_text_to_glyph_index: FAILED **");
        end
        $finish;
    end

    // Hang guard
    initial begin : run_guard
        #RUN_LIMIT;
        $display("** multibyte_text_to_glyph_index: FAILED **");
        $finish;
    end

endmodule
